@@ src/matrix3x3_inverse_assert.svh @@
// Assertion macros for the matrix inverse RTL, included only by matrix3x3_inverse.sv.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

`define M3INV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define M3INV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/m3inv_pkg.sv @@
// Types and constants of the 3x3 matrix inverse pipeline.
// Used by every module of the block; depends on nothing.
package m3inv_pkg;

    localparam int EW    = 32;
    localparam int NE    = 9;
    localparam int PW    = 64;
    localparam int CW    = 65;
    localparam int LO_W  = CW - EW;
    localparam int PLW   = EW + LO_W + 1;
    localparam int MW    = 64;
    localparam int DW    = 98;
    localparam int NW    = 98;
    localparam int QB    = 33;
    localparam int SW    = NW + QB;

    typedef logic [EW-1:0]         t_word;
    typedef logic [NE-1:0][EW-1:0] t_mat;
    typedef logic [3:0]            t_eidx;

    // Element indexes (row * 3 + column) of p, q, r, s for cofactor p*q - r*s.
    localparam t_eidx COF_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    localparam t_eidx COL0_IDX [3] = '{4'd0, 4'd3, 4'd6};

    localparam t_word POS_LIMIT = 32'h7FFF_FFFF;
    localparam t_word NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [NE-1:0][CW-1:0] cof;
        logic [2:0][EW-1:0]    col0;
    } t_cof;

    typedef struct packed {
        logic [NE-1:0][MW-1:0] mag;
        logic [NE-1:0]         neg;
        logic [DW-1:0]         det;
    } t_det;

    typedef struct packed {
        t_mat elem;
        logic singular;
    } t_inv;

endpackage

@@ src/m3inv_mat_if.sv @@
// Input channel of the matrix inverse: one matrix per beat.
// Standalone; carries valid, ready and nine signed Q16.16 elements.
interface m3inv_mat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

@@ src/m3inv_inv_if.sv @@
// Output channel of the matrix inverse: one inverse per beat.
// Standalone; carries valid, ready, nine Q16.16 elements and the singular flag.
interface m3inv_inv_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic               singular;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, output ready);
endinterface

@@ src/matrix3x3_inverse.sv @@
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out.
// Throughput: one matrix per cycle when not stalled, sustained by 41 register stages, 33 of them
// the restoring divider that yields one quotient bit per stage in each of nine lanes.
// Reset clears only the stage valid bits; there is no stored state and no clearing pass.
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m3inv_mat_if.sink   i_mat,
    m3inv_inv_if.source o_inv
);
    import m3inv_pkg::*;

    t_mat w_mat;
    t_cof w_cof;
    t_det w_det;
    t_inv w_inv;
    logic w_cof_vld, w_cof_rdy, w_det_vld, w_det_rdy;

    assign w_mat[0] = i_mat.a00;
    assign w_mat[1] = i_mat.a01;
    assign w_mat[2] = i_mat.a02;
    assign w_mat[3] = i_mat.a10;
    assign w_mat[4] = i_mat.a11;
    assign w_mat[5] = i_mat.a12;
    assign w_mat[6] = i_mat.a20;
    assign w_mat[7] = i_mat.a21;
    assign w_mat[8] = i_mat.a22;

    m3inv_cof u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_mat.valid),
        .o_ready (i_mat.ready),
        .i_mat   (w_mat),
        .o_valid (w_cof_vld),
        .i_ready (w_cof_rdy),
        .o_cof   (w_cof)
    );

    m3inv_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cof_vld),
        .o_ready (w_cof_rdy),
        .i_cof   (w_cof),
        .o_valid (w_det_vld),
        .i_ready (w_det_rdy),
        .o_det   (w_det)
    );

    m3inv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_det_vld),
        .o_ready (w_det_rdy),
        .i_det   (w_det),
        .o_valid (o_inv.valid),
        .i_ready (o_inv.ready),
        .o_inv   (w_inv)
    );

    assign o_inv.r00      = w_inv.elem[0];
    assign o_inv.r01      = w_inv.elem[1];
    assign o_inv.r02      = w_inv.elem[2];
    assign o_inv.r10      = w_inv.elem[3];
    assign o_inv.r11      = w_inv.elem[4];
    assign o_inv.r12      = w_inv.elem[5];
    assign o_inv.r20      = w_inv.elem[6];
    assign o_inv.r21      = w_inv.elem[7];
    assign o_inv.r22      = w_inv.elem[8];
    assign o_inv.singular = w_inv.singular;

    `M3INV_ASSERT_IMP(a_singular_zero, o_inv.valid && o_inv.singular, (w_inv.elem == '0), "singular beat carries a nonzero element")
    `M3INV_ASSERT_IMP(a_ready_flow, o_inv.ready || !o_inv.valid, i_mat.ready, "input stalled while output side is free")
    `M3INV_ASSERT_IMP(a_reset_empty, $past(!i_rst_n), !o_inv.valid, "output beat right after reset")

endmodule

@@ src/m3inv_cof.sv @@
// Cofactor front end: eighteen element products, then nine exact cofactors.
// Two register stages; depends on m3inv_pkg.
module m3inv_cof (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m3inv_pkg::t_mat i_mat,
    output logic            o_valid,
    input  logic            i_ready,
    output m3inv_pkg::t_cof o_cof
);
    import m3inv_pkg::*;

    logic [1:0] r_vld;
    logic [2:0] w_rdy;

    logic [NE-1:0][1:0][PW-1:0] r_prod, n_prod;
    logic [2:0][EW-1:0]         r_col0_a, r_col0_b, n_col0;
    logic [NE-1:0][CW-1:0]      r_cof, n_cof;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[1];
    assign o_cof    = '{cof: r_cof, col0: r_col0_b};

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            n_prod[i][0] = $signed(i_mat[COF_IDX[i][0]]) * $signed(i_mat[COF_IDX[i][1]]);
            n_prod[i][1] = $signed(i_mat[COF_IDX[i][2]]) * $signed(i_mat[COF_IDX[i][3]]);
        end
        for (int k = 0; k < 3; k++) begin
            n_col0[k] = i_mat[COL0_IDX[k]];
        end
        for (int i = 0; i < NE; i++) begin
            n_cof[i] = {r_prod[i][0][PW-1], r_prod[i][0]}
                     - {r_prod[i][1][PW-1], r_prod[i][1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_prod   <= n_prod;
            r_col0_a <= n_col0;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_cof    <= n_cof;
            r_col0_b <= r_col0_a;
        end
    end

endmodule

@@ src/m3inv_det.sv @@
// Determinant by expansion along the first column, plus cofactor magnitudes.
// Three register stages (split products, terms, sum); depends on m3inv_pkg.
module m3inv_det (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m3inv_pkg::t_cof i_cof,
    output logic            o_valid,
    input  logic            i_ready,
    output m3inv_pkg::t_det o_det
);
    import m3inv_pkg::*;

    logic [2:0] r_vld;
    logic [3:0] w_rdy;

    logic [2:0][PW-1:0]    r_ph, n_ph;
    logic [2:0][PLW-1:0]   r_pl, n_pl;
    logic [2:0][DW-1:0]    r_term, n_term;
    logic [DW-1:0]         r_det, n_det;
    logic [NE-1:0][MW-1:0] r_mag_a, r_mag_b, r_mag_c, n_mag;
    logic [NE-1:0]         r_neg_a, r_neg_b, r_neg_c, n_neg;
    logic [CW-1:0]         w_abs;

    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[2];
    assign o_det    = '{mag: r_mag_c, neg: r_neg_c, det: r_det};

    always_comb begin
        w_rdy[3] = i_ready;
        for (int s = 2; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    always_comb begin
        w_abs = '0;
        for (int k = 0; k < 3; k++) begin
            n_ph[k] = $signed(i_cof.col0[k]) * $signed(i_cof.cof[k][CW-1:LO_W]);
            n_pl[k] = $signed(i_cof.col0[k]) * $signed({1'b0, i_cof.cof[k][LO_W-1:0]});
        end
        for (int i = 0; i < NE; i++) begin
            n_neg[i] = i_cof.cof[i][CW-1];
            w_abs    = n_neg[i] ? (~i_cof.cof[i] + 1'b1) : i_cof.cof[i];
            n_mag[i] = w_abs[MW-1:0];
        end
        for (int k = 0; k < 3; k++) begin
            n_term[k] = ({{(DW-PW){r_ph[k][PW-1]}}, r_ph[k]} << LO_W)
                      + {{(DW-PLW){r_pl[k][PLW-1]}}, r_pl[k]};
        end
        n_det = r_term[0] + r_term[1] + r_term[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_ph    <= n_ph;
            r_pl    <= n_pl;
            r_mag_a <= n_mag;
            r_neg_a <= n_neg;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_term  <= n_term;
            r_mag_b <= r_mag_a;
            r_neg_b <= r_neg_a;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_det   <= n_det;
            r_mag_c <= r_mag_b;
            r_neg_c <= r_neg_b;
        end
    end

endmodule

@@ src/m3inv_div.sv @@
// Nine rounded quotients cofactor / determinant with saturation, all zero when the determinant is zero.
// Prep stages, a restoring divider one quotient bit per stage, output stage.
// Depends on m3inv_pkg.
module m3inv_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m3inv_pkg::t_det i_det,
    output logic            o_valid,
    input  logic            i_ready,
    output m3inv_pkg::t_inv o_inv
);
    import m3inv_pkg::*;

    localparam int NL = QB;
    localparam int NS = NL + 3;
    localparam int FS = NS - 1;

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;

    logic [NE-1:0][MW-1:0] r_p0_mag;
    logic [NE-1:0]         r_p0_cneg;
    logic [DW-1:0]         r_p0_absd, n_absd;
    logic                  r_p0_dneg, r_p0_dz, n_dneg, n_dz;

    logic [NE-1:0][NW-1:0] r_rem [NL+1];
    logic [NE-1:0][QB-1:0] r_q   [NL+1];
    logic [NW-1:0]         r_den [NL+1];
    logic [NE-1:0]         r_sgn [NL+1];
    logic                  r_dz  [NL+1];

    logic [NE-1:0][NW-1:0] n_rem0;
    logic [NW-1:0]         n_den0;
    logic [NE-1:0][NW-1:0] n_rem [NL];
    logic [NE-1:0][QB-1:0] n_q   [NL];

    t_inv                  r_out, n_out;
    logic [SW-1:0]         w_sh;
    logic                  w_ge;
    logic                  w_sat;
    t_word                 w_lim, w_mag;

    assign o_ready   = w_rdy[0];
    assign o_valid   = r_vld[FS];
    assign o_inv     = r_out;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    always_comb begin
        w_sh  = '0;
        w_ge  = 1'b0;
        w_sat = 1'b0;
        w_lim = '0;
        w_mag = '0;
        n_dneg = i_det.det[DW-1];
        n_absd = n_dneg ? (~i_det.det + 1'b1) : i_det.det;
        n_dz   = (i_det.det == '0);
        for (int i = 0; i < NE; i++) begin
            n_rem0[i] = {{(NW-MW-QB){1'b0}}, r_p0_mag[i], {QB{1'b0}}} + r_p0_absd;
        end
        n_den0 = {r_p0_absd[NW-2:0], 1'b0};
        for (int j = 0; j < NL; j++) begin
            for (int i = 0; i < NE; i++) begin
                w_sh = {{QB{1'b0}}, r_den[j]} << (NL - 1 - j);
                w_ge = ({{QB{1'b0}}, r_rem[j][i]} >= w_sh);
                n_rem[j][i] = w_ge ? (r_rem[j][i] - w_sh[NW-1:0]) : r_rem[j][i];
                n_q[j][i]   = {r_q[j][i][QB-2:0], w_ge};
            end
        end
        for (int i = 0; i < NE; i++) begin
            w_lim = r_sgn[NL][i] ? NEG_LIMIT : POS_LIMIT;
            w_sat = r_q[NL][i][QB-1] || (r_q[NL][i][EW-1:0] > w_lim);
            w_mag = w_sat ? w_lim : r_q[NL][i][EW-1:0];
            if (r_dz[NL]) begin
                n_out.elem[i] = '0;
            end else begin
                n_out.elem[i] = r_sgn[NL][i] ? (~w_mag + 1'b1) : w_mag;
            end
        end
        n_out.singular = r_dz[NL];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                if (w_rdy[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_p0_mag  <= i_det.mag;
            r_p0_cneg <= i_det.neg;
            r_p0_absd <= n_absd;
            r_p0_dneg <= n_dneg;
            r_p0_dz   <= n_dz;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_rem[0] <= n_rem0;
            r_q[0]   <= '0;
            r_den[0] <= n_den0;
            r_sgn[0] <= r_p0_cneg ^ {NE{r_p0_dneg}};
            r_dz[0]  <= r_p0_dz;
        end
        for (int j = 0; j < NL; j++) begin
            if (w_rdy[j+2] && r_vld[j+1]) begin
                r_rem[j+1] <= n_rem[j];
                r_q[j+1]   <= n_q[j];
                r_den[j+1] <= r_den[j];
                r_sgn[j+1] <= r_sgn[j];
                r_dz[j+1]  <= r_dz[j];
            end
        end
        if (w_rdy[FS] && r_vld[FS-1]) begin
            r_out <= n_out;
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench for matrix3x3_inverse: directed and random matrices, exact inverse prediction.
// Depends on m3inv_pkg, m3inv_mat_if and m3inv_inv_if; drives and checks u_dut.
`timescale 1ns / 100ps

module tb_top;
    import m3inv_pkg::*;

    typedef logic signed [31:0] t_elem;
    typedef struct {
        t_elem a [9];
    } t_matrix;
    typedef struct {
        t_elem r [9];
        logic  singular;
    } t_inverse;

    localparam int LATENCY = 41;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    m3inv_mat_if i_mat ();
    m3inv_inv_if o_inv ();

    matrix3x3_inverse u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (i_mat.sink),
        .o_inv   (o_inv.source)
    );

    t_matrix  pending_mats [$];
    t_inverse expected_invs [$];
    int       mismatches;
    int       inverses_seen;
    int       singular_seen;
    int       saturated_seen;
    int       idle_cycles;
    int       send_wait;
    int       recv_wait;
    bit       stim_done;
    bit       in_fire;
    bit       out_fire;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Rounded, saturated quotient c * 2^32 / d; d is nonzero.
    function automatic t_elem divide_round(logic signed [127:0] c, logic signed [127:0] d);
        logic [127:0] mc;
        logic [127:0] md;
        logic [127:0] q;
        logic         neg;
        logic [127:0] lim;
        neg = c[127] ^ d[127];
        mc  = c[127] ? -c : c;
        md  = d[127] ? -d : d;
        q   = ((mc << 33) + md) / (md << 1);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            q = lim;
        end
        return neg ? t_elem'(-q[31:0]) : t_elem'(q[31:0]);
    endfunction

    function automatic t_inverse invert_matrix(t_matrix m);
        t_inverse           res;
        logic signed [127:0] e [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        for (int i = 0; i < 9; i++) begin
            e[i] = 128'(m.a[i]);
        end
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[3] * e[2] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * cof[0] + e[3] * cof[1] + e[6] * cof[2];
        res.singular = (det == 0);
        for (int i = 0; i < 9; i++) begin
            res.r[i] = res.singular ? '0 : divide_round(cof[i], det);
        end
        return res;
    endfunction

    function automatic t_elem random_elem();
        case ($urandom_range(0, 5))
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(0, 32'h0001_0000 * 8)) - 32'sh0004_0000;
            2: return ($urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000)
                      * $urandom_range(0, 4);
            3: return t_elem'($urandom_range(0, 255)) - 128;
            4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return t_elem'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    task automatic queue_matrix(t_elem v0, t_elem v1, t_elem v2, t_elem v3, t_elem v4,
                                t_elem v5, t_elem v6, t_elem v7, t_elem v8);
        t_matrix m;
        m.a = '{v0, v1, v2, v3, v4, v5, v6, v7, v8};
        pending_mats.push_back(m);
    endtask

    initial begin
        t_matrix m;
        t_elem   one;
        t_elem   mx;
        t_elem   mn;
        one = 32'sh0001_0000;
        mx  = 32'sh7FFF_FFFF;
        mn  = 32'sh8000_0000;
        queue_matrix(one, 0, 0, 0, one, 0, 0, 0, one);
        queue_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_matrix(one, one, one, one, one, one, one, one, one);
        queue_matrix(2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2);
        queue_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
        queue_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1);
        queue_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx);
        queue_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn);
        queue_matrix(mn, mx, mn, mx, mn, mx, mn, mx, mx);
        queue_matrix(mx, mn, 0, mn, mx, 0, 0, 0, mn);
        queue_matrix(0, one, 0, one, 0, 0, 0, 0, one);
        queue_matrix(0, 0, one, 0, one, 0, one, 0, 0);
        queue_matrix(3 * one, one, 0, 0, 0, 0, one, 2 * one, one);
        queue_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        queue_matrix(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0,
                     32'sh3333_3333, 32'shCCCC_CCCC, 32'sh00FF_00FF, 32'shFF00_FF00,
                     32'sh1234_5678);
        queue_matrix(one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 7 * one,
                     8 * one, 10 * one);
        for (int n = 0; n < 534; n++) begin
            for (int i = 0; i < 9; i++) begin
                m.a[i] = random_elem();
            end
            // Some matrices get a repeated row so the determinant is exactly zero.
            if ($urandom_range(0, 9) == 0) begin
                m.a[6] = m.a[0];
                m.a[7] = m.a[1];
                m.a[8] = m.a[2];
            end
            pending_mats.push_back(m);
        end
        stim_done = 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin
        i_mat.valid = 1'b0;
        o_inv.ready = 1'b0;
        {i_mat.a00, i_mat.a01, i_mat.a02, i_mat.a10, i_mat.a11, i_mat.a12,
         i_mat.a20, i_mat.a21, i_mat.a22} = '0;
        mismatches  = 0;
        inverses_seen = 0;
        singular_seen = 0;
        saturated_seen = 0;
        idle_cycles = 0;
        send_wait   = 0;
        recv_wait   = 0;
    end

    // Driver: after each accepted beat, draw a gap before offering the next matrix.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                void'(pending_mats.pop_front());
                send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (!i_mat.valid || in_fire) begin
                if (send_wait > 0 || pending_mats.size() == 0) begin
                    if (send_wait > 0) begin
                        send_wait = send_wait - 1;
                    end
                    i_mat.valid <= 1'b0;
                end else begin
                    i_mat.valid <= 1'b1;
                    {i_mat.a00, i_mat.a01, i_mat.a02, i_mat.a10, i_mat.a11, i_mat.a12,
                     i_mat.a20, i_mat.a21, i_mat.a22} <=
                        {pending_mats[0].a[0], pending_mats[0].a[1], pending_mats[0].a[2],
                         pending_mats[0].a[3], pending_mats[0].a[4], pending_mats[0].a[5],
                         pending_mats[0].a[6], pending_mats[0].a[7], pending_mats[0].a[8]};
                end
            end
        end
    end

    // Receiver back-pressure: ready drops for a drawn number of cycles per beat.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                o_inv.ready <= 1'b0;
            end else begin
                o_inv.ready <= 1'b1;
            end
        end
    end

    // Monitor: predict at input acceptance, compare at output acceptance.
    always @(posedge i_clk) begin
        t_matrix  m;
        t_inverse got;
        t_inverse want;
        bit       bad;
        int       sat_cnt;
        in_fire  <= i_mat.valid && i_mat.ready;
        out_fire <= o_inv.valid && o_inv.ready;
        if (i_rst_n) begin
            if ((i_mat.valid && i_mat.ready) || (o_inv.valid && o_inv.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_mat.valid && i_mat.ready) begin
                m.a = '{i_mat.a00, i_mat.a01, i_mat.a02, i_mat.a10, i_mat.a11,
                        i_mat.a12, i_mat.a20, i_mat.a21, i_mat.a22};
                expected_invs.push_back(invert_matrix(m));
            end
            if (o_inv.valid && o_inv.ready) begin
                got.r = '{o_inv.r00, o_inv.r01, o_inv.r02, o_inv.r10, o_inv.r11,
                          o_inv.r12, o_inv.r20, o_inv.r21, o_inv.r22};
                got.singular = o_inv.singular;
                inverses_seen <= inverses_seen + 1;
                if (got.singular) begin
                    singular_seen <= singular_seen + 1;
                end
                if (expected_invs.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("ERROR: output beat with no matrix outstanding");
                    end
                end else begin
                    want = expected_invs.pop_front();
                    bad = (want.singular !== got.singular);
                    sat_cnt = 0;
                    for (int i = 0; i < 9; i++) begin
                        bad |= (want.r[i] !== got.r[i]);
                        if (want.r[i] == 32'sh7FFF_FFFF || want.r[i] == 32'sh8000_0000) begin
                            sat_cnt++;
                        end
                    end
                    saturated_seen <= saturated_seen + sat_cnt;
                    if (bad) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("ERROR: inverse mismatch, singular exp %0b got %0b",
                                     want.singular, got.singular);
                            for (int i = 0; i < 9; i++) begin
                                $display("  r[%0d] exp %h got %h", i, want.r[i], got.r[i]);
                            end
                        end
                    end
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (!(stim_done && pending_mats.size() == 0 && expected_invs.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d inverses outstanding.", expected_invs.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            $display("Checked %0d inverses, %0d singular, %0d saturated elements.",
                     inverses_seen, singular_seen, saturated_seen);
            if (mismatches == 0 && expected_invs.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
            $finish;
        end
    end
endmodule

@@ files.f @@
+incdir+src
src/m3inv_pkg.sv
src/m3inv_mat_if.sv
src/m3inv_inv_if.sv
src/m3inv_cof.sv
src/m3inv_det.sv
src/m3inv_div.sv
src/matrix3x3_inverse.sv
dv/tb_top.sv
